// File: hw/rtl/utfd_pkg.sv
// Shared types, constants and the lead byte classifier of the UTF-8 sequence decoder.
// No dependencies; every other file of the block imports this package.
`default_nettype none

package utfd_pkg;

   // Number of continuation byte lanes (byte slots one to five).
   localparam int unsigned NUM_LANES = 5;

   // Tag that marks a continuation byte in its two top bits.
   localparam logic [1:0] CONT_TAG = 2'b10;

   // Sequence lengths; zero marks a lead byte that opens no sequence.
   localparam logic [2:0] LEN_BAD   = 3'd0;
   localparam logic [2:0] LEN_ONE   = 3'd1;
   localparam logic [2:0] LEN_TWO   = 3'd2;
   localparam logic [2:0] LEN_THREE = 3'd3;
   localparam logic [2:0] LEN_FOUR  = 3'd4;
   localparam logic [2:0] LEN_FIVE  = 3'd5;
   localparam logic [2:0] LEN_SIX   = 3'd6;

   // Highest and lowest legal values of the available byte count.
   localparam logic [2:0] AVAIL_MAX = 3'd6;
   localparam logic [2:0] AVAIL_MIN = 3'd1;

   // What one lane reports on its byte slot.
   typedef struct packed {
      logic       cont_ok;
      logic [5:0] payload;
   } lane_result_type;

   typedef lane_result_type [NUM_LANES-1:0] lane_bus_type;

   // Sequence length that a lead byte announces.
   function automatic logic [2:0] seq_length(input logic [7:0] lead);
      logic [2:0] len;
      len = LEN_BAD;
      if (lead[7] == 1'b0) begin
         len = LEN_ONE;
      end else if (lead[7:5] == 3'b110) begin
         // 0xC0 and 0xC1 could only encode overlong forms.
         len = (lead[4:1] == 4'b0000) ? LEN_BAD : LEN_TWO;
      end else if (lead[7:4] == 4'b1110) begin
         len = LEN_THREE;
      end else if (lead[7:3] == 5'b11110) begin
         len = LEN_FOUR;
      end else if (lead[7:2] == 6'b111110) begin
         len = LEN_FIVE;
      end else if (lead[7:1] == 7'b1111110) begin
         len = LEN_SIX;
      end
      return len;
   endfunction

endpackage

`default_nettype wire

// File: hw/rtl/utf8_sequence_decoder_top.sv
// Top level of the UTF-8 sequence decoder: byte lanes, a stage register, the merge and the output.
// Depends on utfd_pkg, utfd_lane and utfd_merge.
`default_nettype none

// The decoder takes one sequence in every clock cycle and never raises busy. Each item's
// result is driven for a single cycle, marked by rsp_strobe, once the item has passed
// the stage register and the output register; the receiver cannot stall, so it must
// capture every strobed result. The five continuation lanes check their bytes while
// the item is presented and a stage register holds their findings; the merging stage,
// which classifies the lead byte and assembles the code point, works in the next cycle
// and feeds the output register that drives the result ports.
module utf8_sequence_decoder_top (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        start,
   output logic             busy,
   input  wire logic [7:0]  req_byte_0,
   input  wire logic [7:0]  req_byte_1,
   input  wire logic [7:0]  req_byte_2,
   input  wire logic [7:0]  req_byte_3,
   input  wire logic [7:0]  req_byte_4,
   input  wire logic [7:0]  req_byte_5,
   input  wire logic [2:0]  req_avail_bytes,
   output logic             rsp_strobe,
   output logic [30:0]      rsp_code_point,
   output logic [2:0]       rsp_consumed,
   output logic             rsp_decode_error
);
   import utfd_pkg::*;

   logic [7:0]   slot_bytes [NUM_LANES];
   lane_bus_type lanes_in;
   lane_bus_type lanes_ff;
   logic [7:0]   lead_ff;
   logic [2:0]   avail_in;
   logic [2:0]   avail_ff;
   logic         stage_valid_in;
   logic         stage_valid_ff;
   logic         accept;

   logic [30:0]  merge_cp;
   logic [2:0]   merge_consumed;
   logic         merge_error;

   logic         rsp_strobe_ff;
   logic [30:0]  rsp_code_point_ff;
   logic [2:0]   rsp_consumed_ff;
   logic         rsp_decode_error_ff;

   // The pipeline takes an item in every cycle.
   assign busy   = 1'b0;
   assign accept = start && !busy;

   assign slot_bytes[0] = req_byte_1;
   assign slot_bytes[1] = req_byte_2;
   assign slot_bytes[2] = req_byte_3;
   assign slot_bytes[3] = req_byte_4;
   assign slot_bytes[4] = req_byte_5;

   // One lane for each byte slot after the lead.
   for (genvar g = 0; g < NUM_LANES; g++) begin : g_lane
      utfd_lane u_lane (
         .slot_byte (slot_bytes[g]),
         .result    (lanes_in[g])
      );
   end

   // The available count is clamped to the range one to six.
   always_comb begin
      if (req_avail_bytes > AVAIL_MAX) begin
         avail_in = AVAIL_MAX;
      end else if (req_avail_bytes < AVAIL_MIN) begin
         avail_in = AVAIL_MIN;
      end else begin
         avail_in = req_avail_bytes;
      end
   end

   assign stage_valid_in = accept;

   // Stage register between the lanes and the merge.
   always_ff @(posedge clock) begin
      if (reset) begin
         stage_valid_ff <= 1'b0;
      end else begin
         stage_valid_ff <= stage_valid_in;
      end
      lanes_ff <= lanes_in;
      lead_ff  <= req_byte_0;
      avail_ff <= avail_in;
   end

   utfd_merge u_merge (
      .lead         (lead_ff),
      .avail        (avail_ff),
      .lanes        (lanes_ff),
      .code_point   (merge_cp),
      .consumed     (merge_consumed),
      .decode_error (merge_error)
   );

   // Output register; each result is shown for exactly one cycle.
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_strobe_ff <= 1'b0;
      end else begin
         rsp_strobe_ff <= stage_valid_ff;
      end
      rsp_code_point_ff   <= merge_cp;
      rsp_consumed_ff     <= merge_consumed;
      rsp_decode_error_ff <= merge_error;
   end

   assign rsp_strobe       = rsp_strobe_ff;
   assign rsp_code_point   = rsp_code_point_ff;
   assign rsp_consumed     = rsp_consumed_ff;
   assign rsp_decode_error = rsp_decode_error_ff;

`ifndef SYNTH
   // Every accepted item yields exactly one result, through the stage register and then the output register.
   a_result_follows_item: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe == ($past(start, 2) && !$past(reset, 2) && !$past(reset, 1)))
      else $error("result strobe does not match accepted items");

   // An error result carries no length and no code point.
   a_error_clears_fields: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe && rsp_decode_error |-> (rsp_consumed == LEN_BAD) && (rsp_code_point == '0))
      else $error("error result with nonzero fields");

   // A good result has a length from one to six.
   a_good_length: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe && !rsp_decode_error |-> (rsp_consumed >= LEN_ONE) && (rsp_consumed <= LEN_SIX))
      else $error("good result with an impossible length");

   // A single-byte result passes the lead byte through unchanged.
   a_ascii_pass: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe && (rsp_consumed == LEN_ONE) |-> rsp_code_point[30:7] == '0)
      else $error("single-byte result above seven bits");
`endif

endmodule

`default_nettype wire

// File: hw/rtl/utfd_lane.sv
// One continuation byte lane: checks the tag of its byte and strips it to six payload bits.
// Depends on utfd_pkg for the lane result type and the tag constant.
`default_nettype none

module utfd_lane (
   input  wire logic [7:0]                slot_byte,
   output utfd_pkg::lane_result_type      result
);
   import utfd_pkg::*;

   // A continuation byte carries the tag in its two top bits.
   assign result.cont_ok = (slot_byte[7:6] == CONT_TAG);
   assign result.payload = slot_byte[5:0];

endmodule

`default_nettype wire

// File: hw/rtl/utfd_merge.sv
// Merging stage: classifies the lead byte, combines the lane checks and assembles the code point.
// Depends on utfd_pkg for the lane bus type, the length codes and the lead classifier.
`default_nettype none

module utfd_merge (
   input  wire logic [7:0]          lead,
   input  wire logic [2:0]          avail,
   input  wire utfd_pkg::lane_bus_type lanes,
   output logic [30:0]              code_point,
   output logic [2:0]               consumed,
   output logic                     decode_error
);
   import utfd_pkg::*;

   logic [2:0]  len;
   logic        cont_bad;
   logic        overlong;
   logic [30:0] cp_raw;
   logic        fail;

   assign len = seq_length(lead);

   // Every byte after the lead and inside the sequence must be a continuation byte.
   always_comb begin
      cont_bad = 1'b0;
      for (int k = 0; k < NUM_LANES; k++) begin
         if ((3'(k + 1) < len) && !lanes[k].cont_ok) begin
            cont_bad = 1'b1;
         end
      end
   end

   // Assemble the code point and check for forms that fit a shorter sequence.
   always_comb begin
      cp_raw   = '0;
      overlong = 1'b0;
      unique case (len)
         LEN_ONE: begin
            cp_raw = {24'd0, lead[6:0]};
         end
         LEN_TWO: begin
            cp_raw = {20'd0, lead[4:0], lanes[0].payload};
         end
         LEN_THREE: begin
            cp_raw   = {15'd0, lead[3:0], lanes[0].payload, lanes[1].payload};
            overlong = (lead[3:0] == 4'd0) && (lanes[0].payload[5] == 1'b0);
         end
         LEN_FOUR: begin
            cp_raw   = {10'd0, lead[2:0], lanes[0].payload, lanes[1].payload,
                        lanes[2].payload};
            overlong = (lead[2:0] == 3'd0) && (lanes[0].payload[5:4] == 2'd0);
         end
         LEN_FIVE: begin
            cp_raw   = {5'd0, lead[1:0], lanes[0].payload, lanes[1].payload,
                        lanes[2].payload, lanes[3].payload};
            overlong = (lead[1:0] == 2'd0) && (lanes[0].payload[5:3] == 3'd0);
         end
         LEN_SIX: begin
            cp_raw   = {lead[0], lanes[0].payload, lanes[1].payload,
                        lanes[2].payload, lanes[3].payload, lanes[4].payload};
            overlong = (lead[0] == 1'b0) && (lanes[0].payload[5:2] == 4'd0);
         end
         default: begin
            cp_raw   = '0;
            overlong = 1'b0;
         end
      endcase
   end

   // A bad lead, a truncated sequence, a bad continuation or an overlong form all fail.
   assign fail = (len == LEN_BAD) || (avail < len) || cont_bad || overlong;

   assign code_point   = fail ? '0 : cp_raw;
   assign consumed     = fail ? LEN_BAD : len;
   assign decode_error = fail;

endmodule

`default_nettype wire
